// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, off during reset.
`define CHK_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ===== rtl/tle_pkg.sv =====
// Package for the terminal line editor: types, codes and constants.
`default_nettype none
package tle_pkg;
  localparam int LineMaxDef   = 16;
  localparam int EscapeMaxDef = 8;
  localparam int CmdQDepth    = 2;

  localparam logic [7:0] KeyEsc   = 8'h1b;
  localparam logic [7:0] KeyBs    = 8'h08;
  localparam logic [7:0] KeyDel   = 8'h7f;
  localparam logic [7:0] KeyCtrlC = 8'h03;
  localparam logic [7:0] KeyCr    = 8'h0d;
  localparam logic [7:0] KeyLf    = 8'h0a;
  localparam logic [7:0] KeyLbr   = 8'h5b;
  localparam logic [7:0] KeySpace = 8'h20;

  localparam logic [1:0] KindEcho = 2'd0;
  localparam logic [1:0] KindLine = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  typedef enum logic [2:0] {
    OP_INSERT, OP_BS, OP_DEL, OP_LEFT, OP_RIGHT, OP_ENTER, OP_CANCEL
  } op_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [7:0] cnt;   // move count, 255 = unlimited, 0 = to home/end
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_SHIFT, S_INS_ECHO, S_INS_BACK, S_DEL_SHIFT, S_DEL_ECHO,
    S_DEL_NUL, S_DEL_SP, S_DEL_BACK, S_MOVE, S_TXT, S_LINE, S_END, S_NONE
  } bstate_t;
endpackage
`default_nettype wire

// ===== rtl/tle_front.sv =====
// Front end: escape collection, count parsing, keystroke classification.
`default_nettype none
module tle_front #(
  parameter int EscapeMax = tle_pkg::EscapeMaxDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          key_valid,
  input  wire logic [7:0]    key,
  output logic               key_stall,
  output logic               cmd_valid,
  output tle_pkg::cmd_t      cmd,
  input  wire logic          cmd_stall
);
  localparam int SW = $clog2(EscapeMax + 3);
  // Count parse runs incrementally as bytes arrive.
  typedef enum logic [1:0] {P_LEAD, P_DIG, P_STOP} pst_t;

  logic [SW-1:0] stage_r, stage_nxt;
  pst_t          pst_r, pst_nxt;
  logic          neg_r, neg_nxt;
  logic [7:0]    mag_r, mag_nxt;
  logic          is_print, is_letter, accept;
  logic [11:0]   mag_x;
  logic [7:0]    cnt_v;

  assign key_stall = cmd_stall;
  assign accept    = key_valid && !cmd_stall;
  assign is_print  = key >= 8'h20 && key <= 8'h7e;
  assign is_letter = (key >= 8'h41 && key <= 8'h5a) || (key >= 8'h61 && key <= 8'h7a);
  assign mag_x     = 12'(mag_r) * 12'd10 + 12'(key - 8'h30);

  always_comb begin
    stage_nxt = stage_r; pst_nxt = pst_r; neg_nxt = neg_r; mag_nxt = mag_r;
    cmd_valid = 1'b0;
    cmd = '{op: tle_pkg::OP_INSERT, ch: key, cnt: 8'd0};
    cnt_v = (mag_r == 8'd0) ? 8'd1 : (neg_r ? 8'd255 : mag_r);
    if (key == tle_pkg::KeyEsc) begin
      stage_nxt = SW'(1);
    end else if (is_print) begin
      if (stage_r == '0) begin
        cmd_valid = 1'b1;
      end else if (stage_r == SW'(1)) begin
        if (key == tle_pkg::KeyLbr) begin
          stage_nxt = SW'(2); pst_nxt = P_LEAD; neg_nxt = 1'b0; mag_nxt = '0;
        end else begin
          stage_nxt = '0; cmd_valid = 1'b1;
        end
      end else if (stage_r >= SW'(EscapeMax + 2)) begin
        stage_nxt = '0; cmd_valid = 1'b1;
      end else if (is_letter) begin
        stage_nxt = '0;
        case (key)
          8'h44: begin cmd_valid = 1'b1; cmd.op = tle_pkg::OP_LEFT;  cmd.cnt = cnt_v; end
          8'h48: begin cmd_valid = 1'b1; cmd.op = tle_pkg::OP_LEFT;  cmd.cnt = 8'd0; end
          8'h43: begin cmd_valid = 1'b1; cmd.op = tle_pkg::OP_RIGHT; cmd.cnt = cnt_v; end
          8'h46: begin cmd_valid = 1'b1; cmd.op = tle_pkg::OP_RIGHT; cmd.cnt = 8'd0; end
          default: ;
        endcase
      end else begin
        stage_nxt = stage_r + SW'(1);
        case (pst_r)
          P_LEAD: begin
            if (key == tle_pkg::KeySpace) pst_nxt = P_LEAD;
            else if (key == 8'h2b || key == 8'h2d) begin
              neg_nxt = key == 8'h2d; pst_nxt = P_DIG;
            end else if (key >= 8'h30 && key <= 8'h39) begin
              mag_nxt = key - 8'h30; pst_nxt = P_DIG;
            end else pst_nxt = P_STOP;
          end
          P_DIG: begin
            if (key >= 8'h30 && key <= 8'h39)
              mag_nxt = (mag_x > 12'd255) ? 8'd255 : mag_x[7:0];
            else pst_nxt = P_STOP;
          end
          default: ;
        endcase
      end
    end else if (key == tle_pkg::KeyBs) begin
      cmd_valid = 1'b1; cmd.op = tle_pkg::OP_BS;
    end else if (key == tle_pkg::KeyDel) begin
      cmd_valid = 1'b1; cmd.op = tle_pkg::OP_DEL;
    end else if (key == tle_pkg::KeyCr) begin
      cmd_valid = 1'b1; cmd.op = tle_pkg::OP_ENTER; stage_nxt = '0;
    end else if (key == tle_pkg::KeyCtrlC) begin
      cmd_valid = 1'b1; cmd.op = tle_pkg::OP_CANCEL; stage_nxt = '0;
    end
    cmd_valid = cmd_valid && key_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0; pst_r <= P_LEAD; neg_r <= 1'b0; mag_r <= '0;
    end else if (accept) begin
      stage_r <= stage_nxt; pst_r <= pst_nxt; neg_r <= neg_nxt; mag_r <= mag_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tle_cmdq.sv =====
// Short command queue between front and back end.
`default_nettype none
`include "assert_macros.svh"
module tle_cmdq #(
  parameter int Depth = tle_pkg::CmdQDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  input  wire tle_pkg::cmd_t wr_data,
  output logic               wr_stall,
  output logic               rd_valid,
  output tle_pkg::cmd_t      rd_data,
  input  wire logic          rd_take
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  tle_pkg::cmd_t   mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r, cnt_inc;
  logic            do_wr, do_rd;

  assign wr_stall = cnt_r == (AW+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_take && rd_valid;
  assign cnt_inc  = cnt_r + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  `CHK_IMPLY(a_no_overfill, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(Depth), "queue overfilled")
  `CHK_NEXT(a_fill_tracks, clk, rst_n, do_wr && !do_rd, cnt_r == $past(cnt_inc), "count slip")
  `CHK_IMPLY(a_take_valid, clk, rst_n, rd_take, rd_valid, "take from empty queue")
endmodule
`default_nettype wire

// ===== rtl/tle_back.sv =====
// Back end: edits the line store and streams result words.
`default_nettype none
`include "assert_macros.svh"
module tle_back #(
  parameter int LineMax = tle_pkg::LineMaxDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire tle_pkg::cmd_t cmd,
  output logic               cmd_take,
  input  wire logic [4:0]    max_length,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic               out_status,
  output logic [4:0]         out_final_length,
  output logic               out_last,
  input  wire logic          out_stall
);
  localparam int CW = $clog2(LineMax + 1);
  localparam int AW = (LineMax > 1) ? $clog2(LineMax) : 1;

  tle_pkg::bstate_t st_r, st_nxt;
  logic [7:0]    line_r [LineMax];
  logic [CW-1:0] len_r, len_nxt, cur_r, cur_nxt, i_r, i_nxt, old_r, old_nxt;
  logic [7:0]    ch_r, ch_nxt, cnt_r, cnt_nxt, ctr_r, ctr_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_a;
  logic [7:0]    wr_d;
  logic          o_v_r, o_v_nxt, go;
  logic [1:0]    o_k_r, o_k_nxt;
  logic [7:0]    o_b_r, o_b_nxt;
  logic          o_s_r, o_s_nxt, o_l_r, o_l_nxt;
  logic [4:0]    o_f_r, o_f_nxt;
  logic [CW-1:0] lim;
  logic          can_out;
  logic          end_step;

  // Each emit holds in the output register; advance only when it can be replaced.
  assign can_out = !o_v_r || !out_stall;
  assign lim = (32'(max_length) > LineMax) ? CW'(LineMax) : CW'(max_length);
  assign end_step = can_out && st_r == tle_pkg::S_END;

  always_comb begin
    st_nxt = st_r; len_nxt = len_r; cur_nxt = cur_r; i_nxt = i_r; old_nxt = old_r;
    ch_nxt = ch_r; cnt_nxt = cnt_r; ctr_nxt = ctr_r;
    wr_en = 1'b0; wr_a = '0; wr_d = ch_r;
    cmd_take = 1'b0; go = 1'b0;
    o_k_nxt = tle_pkg::KindEcho; o_b_nxt = 8'd0; o_s_nxt = 1'b0; o_f_nxt = '0;
    o_l_nxt = 1'b0;
    if (can_out) begin
      unique case (st_r)
        tle_pkg::S_IDLE: begin
          if (cmd_valid) begin
            cmd_take = 1'b1; ch_nxt = cmd.ch; cnt_nxt = cmd.cnt; ctr_nxt = 8'd0;
            unique case (cmd.op)
              tle_pkg::OP_INSERT:
                if (len_r < lim) begin st_nxt = tle_pkg::S_INS_SHIFT; i_nxt = len_r; end
              tle_pkg::OP_BS:
                if (len_r != '0 && cur_r != '0) begin
                  go = 1'b1; o_b_nxt = tle_pkg::KeyBs; cur_nxt = cur_r - CW'(1);
                  o_l_nxt = cur_r > len_r;  // only when no char remains after
                  old_nxt = len_r; i_nxt = cur_r - CW'(1);
                  if (cur_r - CW'(1) < len_r) st_nxt = tle_pkg::S_DEL_SHIFT;
                end
              tle_pkg::OP_DEL:
                if (len_r != '0 && cur_r < len_r) begin
                  old_nxt = len_r; i_nxt = cur_r; st_nxt = tle_pkg::S_DEL_SHIFT;
                end
              tle_pkg::OP_LEFT: begin
                if (cmd.cnt == 8'd0) cnt_nxt = 8'(cur_r);
                st_nxt = tle_pkg::S_MOVE;
              end
              tle_pkg::OP_RIGHT: begin
                if (cmd.cnt == 8'd0) cnt_nxt = 8'(len_r - cur_r);
                st_nxt = tle_pkg::S_MOVE;
              end
              tle_pkg::OP_ENTER: begin
                go = 1'b1; o_b_nxt = tle_pkg::KeyCr; st_nxt = tle_pkg::S_TXT;
              end
              tle_pkg::OP_CANCEL: begin
                go = 1'b1; o_b_nxt = 8'h5e; st_nxt = tle_pkg::S_TXT;
              end
              default: ;
            endcase
          end
        end
        tle_pkg::S_INS_SHIFT: begin
          if (i_r > cur_r) begin
            wr_en = 1'b1; wr_a = AW'(i_r); wr_d = line_r[AW'(i_r - CW'(1))];
            i_nxt = i_r - CW'(1);
          end else begin
            wr_en = 1'b1; wr_a = AW'(cur_r);
            cur_nxt = cur_r + CW'(1); len_nxt = len_r + CW'(1);
            i_nxt = cur_r; st_nxt = tle_pkg::S_INS_ECHO;
          end
        end
        tle_pkg::S_INS_ECHO: begin
          go = 1'b1; o_b_nxt = line_r[AW'(i_r)]; i_nxt = i_r + CW'(1);
          if (i_r + CW'(1) == len_r) begin
            i_nxt = cur_r;
            if (cur_r == len_r) begin o_l_nxt = 1'b1; st_nxt = tle_pkg::S_IDLE; end
            else st_nxt = tle_pkg::S_INS_BACK;
          end
        end
        tle_pkg::S_INS_BACK: begin
          go = 1'b1; o_b_nxt = tle_pkg::KeyBs; i_nxt = i_r + CW'(1);
          if (i_r + CW'(1) == len_r) begin o_l_nxt = 1'b1; st_nxt = tle_pkg::S_IDLE; end
        end
        tle_pkg::S_DEL_SHIFT: begin
          if (i_r + CW'(1) < old_r) begin
            wr_en = 1'b1; wr_a = AW'(i_r); wr_d = line_r[AW'(i_r + CW'(1))];
            i_nxt = i_r + CW'(1);
          end else begin
            i_nxt = cur_r;
            st_nxt = (cur_r + CW'(1) < old_r) ? tle_pkg::S_DEL_ECHO : tle_pkg::S_DEL_NUL;
          end
        end
        tle_pkg::S_DEL_ECHO: begin
          go = 1'b1; o_b_nxt = line_r[AW'(i_r)]; i_nxt = i_r + CW'(1);
          if (i_r + CW'(2) >= old_r) st_nxt = tle_pkg::S_DEL_NUL;
        end
        tle_pkg::S_DEL_NUL: begin
          go = 1'b1; o_b_nxt = 8'h00; st_nxt = tle_pkg::S_DEL_SP;
        end
        tle_pkg::S_DEL_SP: begin
          go = 1'b1; o_b_nxt = tle_pkg::KeySpace; st_nxt = tle_pkg::S_DEL_BACK;
          ctr_nxt = 8'(old_r) + 8'd1 - 8'(cur_r);
        end
        tle_pkg::S_DEL_BACK: begin
          go = 1'b1; o_b_nxt = tle_pkg::KeyBs; ctr_nxt = ctr_r - 8'd1;
          if (ctr_r == 8'd1) begin
            o_l_nxt = 1'b1; len_nxt = old_r - CW'(1); st_nxt = tle_pkg::S_IDLE;
          end
        end
        tle_pkg::S_MOVE: begin
          // last flag needs to know whether another step follows
          if (ch_r == 8'h44 || ch_r == 8'h48) begin
            if (cur_r != '0 && cnt_r != 8'd0) begin
              go = 1'b1; o_b_nxt = tle_pkg::KeyBs;
              cur_nxt = cur_r - CW'(1); cnt_nxt = cnt_r - 8'd1;
              o_l_nxt = cur_r == CW'(1) || cnt_r == 8'd1;
              if (o_l_nxt) st_nxt = tle_pkg::S_IDLE;
            end else st_nxt = tle_pkg::S_IDLE;
          end else begin
            if (cur_r < len_r && cnt_r != 8'd0) begin
              go = 1'b1; o_b_nxt = line_r[AW'(cur_r)];
              cur_nxt = cur_r + CW'(1); cnt_nxt = cnt_r - 8'd1;
              o_l_nxt = cur_r + CW'(1) == len_r || cnt_r == 8'd1;
              if (o_l_nxt) st_nxt = tle_pkg::S_IDLE;
            end else st_nxt = tle_pkg::S_IDLE;
          end
        end
        tle_pkg::S_TXT: begin
          // ctr counts the fixed echo words after the first one
          go = 1'b1; ctr_nxt = ctr_r + 8'd1;
          if (ch_r == tle_pkg::KeyCtrlC) begin
            unique case (ctr_r[1:0])
              2'd0: o_b_nxt = 8'h43;
              2'd1: o_b_nxt = tle_pkg::KeyCr;
              default: begin o_b_nxt = tle_pkg::KeyLf; st_nxt = tle_pkg::S_END; end
            endcase
          end else begin
            o_b_nxt = tle_pkg::KeyLf; i_nxt = '0;
            st_nxt = (len_r != '0) ? tle_pkg::S_LINE : tle_pkg::S_END;
          end
        end
        tle_pkg::S_LINE: begin
          go = 1'b1; o_k_nxt = tle_pkg::KindLine; o_b_nxt = line_r[AW'(i_r)];
          i_nxt = i_r + CW'(1);
          if (i_r + CW'(1) == len_r) st_nxt = tle_pkg::S_END;
        end
        tle_pkg::S_END: begin
          go = 1'b1; o_k_nxt = tle_pkg::KindEnd; o_l_nxt = 1'b1;
          if (ch_r == tle_pkg::KeyCtrlC) o_s_nxt = 1'b1;
          else o_f_nxt = 5'(len_r);
          len_nxt = '0; cur_nxt = '0; st_nxt = tle_pkg::S_IDLE;
        end
        default: st_nxt = tle_pkg::S_IDLE;
      endcase
    end
    o_v_nxt = go ? 1'b1 : (o_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (wr_en) line_r[wr_a] <= wr_d;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      o_k_r <= o_k_nxt; o_b_r <= o_b_nxt; o_s_r <= o_s_nxt;
      o_f_r <= o_f_nxt; o_l_r <= o_l_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tle_pkg::S_IDLE; len_r <= '0; cur_r <= '0; o_v_r <= 1'b0;
      i_r <= '0; old_r <= '0; ch_r <= '0; cnt_r <= '0; ctr_r <= '0;
    end else begin
      st_r <= st_nxt; len_r <= len_nxt; cur_r <= cur_nxt; o_v_r <= o_v_nxt;
      i_r <= i_nxt; old_r <= old_nxt; ch_r <= ch_nxt; cnt_r <= cnt_nxt; ctr_r <= ctr_nxt;
    end
  end

  assign out_valid        = o_v_r;
  assign out_kind         = o_k_r;
  assign out_byte         = o_b_r;
  assign out_status       = o_s_r;
  assign out_final_length = o_f_r;
  assign out_last         = o_l_r;

  `CHK_IMPLY(a_cursor_in_line, clk, rst_n, 1'b1, cur_r <= len_r, "cursor past end")
  `CHK_IMPLY(a_len_limit, clk, rst_n, 1'b1, len_r <= CW'(LineMax), "line overflow")
  `CHK_NEXT(a_end_clears, clk, rst_n, end_step, len_r == '0 && cur_r == '0, "line not cleared")
endmodule
`default_nettype wire

// ===== rtl/terminal_line_editor.sv =====
// Top level of the terminal line editor: front, command queue, back, config.
//
//  channel  | handshake              | payload
//  in_      | in_valid / in_stall    | in_key_byte
//  out_     | out_valid / out_stall  | out_kind, out_out_byte, out_status,
//           |                        | out_final_length, out_last
//  cfg_     | APB write/read         | max_length at address 0
//
// The front classifies one keystroke per cycle while the queue is not full;
// escape bytes produce no word. A command is registered in the queue; the back
// then takes it in S_IDLE, shifts the buffer an entry at a time, and emits words.
// Worst case is a backspace at column 1 of a full 16-char line: 35 words.
// The output register holds a word under out_stall and the back waits on it.
// Reset (synchronous, rst_n low) empties the line, queue and escape state and
// sets max_length to 16.
`default_nettype none
module terminal_line_editor #(
  parameter int LineMax   = tle_pkg::LineMaxDef,
  parameter int EscapeMax = tle_pkg::EscapeMaxDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_key_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_out_byte,
  output logic            out_status,
  output logic [4:0]      out_final_length,
  output logic            out_last,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  logic [4:0]    max_len_r;
  logic          fq_valid, fq_stall, q_valid, q_take;
  tle_pkg::cmd_t fq_cmd, q_cmd;

  // Config register: max_length lives at byte 0.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {27'd0, max_len_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= 5'd16;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      max_len_r <= cfg_pwdata[4:0];
  end

  tle_front #(.EscapeMax(EscapeMax)) u_front (
    .clk, .rst_n, .key_valid(in_valid), .key(in_key_byte), .key_stall(in_stall),
    .cmd_valid(fq_valid), .cmd(fq_cmd), .cmd_stall(fq_stall)
  );

  tle_cmdq u_q (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_data(fq_cmd), .wr_stall(fq_stall),
    .rd_valid(q_valid), .rd_data(q_cmd), .rd_take(q_take)
  );

  tle_back #(.LineMax(LineMax)) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd(q_cmd), .cmd_take(q_take),
    .max_length(max_len_r), .out_valid, .out_kind, .out_byte(out_out_byte),
    .out_status, .out_final_length, .out_last, .out_stall
  );
endmodule
`default_nettype wire

// ===== sim/tb_terminal_line_editor.sv =====
// Testbench for the terminal line editor: keystroke streams checked against an echo predictor.
`default_nettype none
module tb_terminal_line_editor;

  localparam int LINE_CAP   = 16;
  localparam int ESC_CAP    = 8;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] ADDR_MAX_LEN = 2'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       status;
    logic [4:0] flen;
    logic       last;
  } echo_word_t;

  // Scoreboard: tracks the editor state and the queue of expected words.
  class editor_scoreboard;
    logic [7:0] line_buf [LINE_CAP];
    logic [7:0] esc_buf [ESC_CAP];
    int unsigned line_len, cur, esc_stage, max_len;
    echo_word_t pending [$];
    int errors;

    function void clear_all();
      line_len = 0; cur = 0; esc_stage = 0; max_len = 16;
      pending.delete(); errors = 0;
    endfunction

    function void emit(logic [1:0] k, logic [7:0] b, logic st, logic [4:0] fl);
      echo_word_t w;
      w.kind = k; w.data = b; w.status = st; w.flen = fl; w.last = 1'b0;
      pending.push_back(w);
    endfunction

    function int unsigned esc_value(int unsigned n);
      int unsigned i, mag;
      bit neg;
      i = 0; mag = 0; neg = 0;
      while (i < n && esc_buf[i] == tle_pkg::KeySpace) i++;
      if (i < n && (esc_buf[i] == "+" || esc_buf[i] == "-")) begin
        neg = (esc_buf[i] == "-");
        i++;
      end
      while (i < n && esc_buf[i] >= "0" && esc_buf[i] <= "9") begin
        mag = mag * 10 + (esc_buf[i] - "0");
        if (mag > 255) mag = 255;
        i++;
      end
      if (mag == 0) return 1;
      return neg ? 255 : mag;
    endfunction

    function void cursor_move(logic [7:0] letter, int unsigned n);
      int unsigned cnt;
      cnt = esc_value(n);
      if (letter == "D" || letter == "H") begin
        if (letter == "H") cnt = cur;
        while (cur > 0 && cnt > 0) begin
          emit(tle_pkg::KindEcho, tle_pkg::KeyBs, 0, 0); cur--; cnt--;
        end
      end
      if (letter == "C" || letter == "F") begin
        if (letter == "F") cnt = line_len - cur;
        while (cur < line_len && cnt > 0) begin
          emit(tle_pkg::KindEcho, line_buf[cur], 0, 0); cur++; cnt--;
        end
      end
    endfunction

    function void insert_char(logic [7:0] c);
      int unsigned lim;
      lim = (max_len > LINE_CAP) ? LINE_CAP : max_len;
      if (line_len >= lim) return;
      for (int unsigned i = line_len; i > cur; i--) line_buf[i] = line_buf[i-1];
      line_buf[cur] = c;
      cur++; line_len++;
      for (int unsigned i = cur - 1; i < line_len; i++)
        emit(tle_pkg::KindEcho, line_buf[i], 0, 0);
      for (int unsigned i = cur; i < line_len; i++)
        emit(tle_pkg::KindEcho, tle_pkg::KeyBs, 0, 0);
    endfunction

    function void delete_char(logic [7:0] c);
      int unsigned old;
      if (line_len == 0) return;
      if (c == tle_pkg::KeyBs) begin
        if (cur == 0) return;
        cur--;
        emit(tle_pkg::KindEcho, tle_pkg::KeyBs, 0, 0);
      end
      if (cur >= line_len) return;
      old = line_len;
      for (int unsigned i = cur; i + 1 < old; i++) line_buf[i] = line_buf[i+1];
      for (int unsigned i = cur; i + 1 < old; i++)
        emit(tle_pkg::KindEcho, line_buf[i], 0, 0);
      emit(tle_pkg::KindEcho, 8'h00, 0, 0);
      emit(tle_pkg::KindEcho, tle_pkg::KeySpace, 0, 0);
      for (int unsigned i = old + 1; i > cur; i--)
        emit(tle_pkg::KindEcho, tle_pkg::KeyBs, 0, 0);
      line_len--;
    endfunction

    // Predict the words one accepted keystroke causes.
    function void note_key(logic [7:0] c);
      int unsigned before_n;
      bit ins;
      int unsigned idx;
      before_n = pending.size();
      if (c == tle_pkg::KeyEsc) begin
        esc_stage = 1;
      end else if (c >= 8'h20 && c <= 8'h7e) begin
        ins = 1;
        if (esc_stage != 0) begin
          ins = 0;
          if (esc_stage == 1) begin
            if (c == tle_pkg::KeyLbr) esc_stage = 2;
            else begin
              esc_stage = 0; ins = 1;
            end
          end else begin
            idx = esc_stage - 2;
            if (idx >= ESC_CAP) begin
              esc_stage = 0; ins = 1;
            end else begin
              esc_buf[idx] = c;
              if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
                cursor_move(c, idx + 1);
                esc_stage = 0;
              end else esc_stage++;
            end
          end
        end
        if (ins) insert_char(c);
      end else if (c == tle_pkg::KeyBs || c == tle_pkg::KeyDel) begin
        delete_char(c);
      end else if (c == tle_pkg::KeyCtrlC) begin
        emit(tle_pkg::KindEcho, "^", 0, 0); emit(tle_pkg::KindEcho, "C", 0, 0);
        emit(tle_pkg::KindEcho, tle_pkg::KeyCr, 0, 0);
        emit(tle_pkg::KindEcho, tle_pkg::KeyLf, 0, 0);
        emit(tle_pkg::KindEnd, 8'h00, 1, 0);
        line_len = 0; cur = 0; esc_stage = 0;
      end else if (c == tle_pkg::KeyCr) begin
        emit(tle_pkg::KindEcho, tle_pkg::KeyCr, 0, 0);
        emit(tle_pkg::KindEcho, tle_pkg::KeyLf, 0, 0);
        for (int unsigned i = 0; i < line_len; i++)
          emit(tle_pkg::KindLine, line_buf[i], 0, 0);
        emit(tle_pkg::KindEnd, 8'h00, 0, line_len[4:0]);
        line_len = 0; cur = 0; esc_stage = 0;
      end
      if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_word(echo_word_t got);
      echo_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, exp none got %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind exp %0d got %0d", $realtime, want.kind, got.kind); errors++;
      end
      if (got.data != want.data) begin
        $display("%0t: byte exp %h got %h", $realtime, want.data, got.data); errors++;
      end
      if (got.status != want.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status); errors++;
      end
      if (got.flen != want.flen) begin
        $display("%0t: length exp %0d got %0d", $realtime, want.flen, got.flen); errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last exp %0d got %0d", $realtime, want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_key_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic out_status;
  logic [4:0] out_final_length;
  logic out_last;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  editor_scoreboard sb;
  int unsigned cycles = 0;
  bit hold_long = 0;   // request for one long receiver hold-off
  bit sink_on = 0;

  always #4 clk = ~clk;

  terminal_line_editor DUT (.*);

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Scoreboard hooks: sample accepted words on the same edge they move.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_key(in_key_byte);
    if (rst_n && out_valid && !out_stall)
      sb.check_word({out_kind, out_out_byte, out_status, out_final_length, out_last});
  end

  // Receiver: random stalls per word, plus one counted long hold-off on request.
  initial begin
    int unsigned gap;
    wait (sink_on);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 1)) gap = 0;   // stretches of full throughput
        repeat (gap) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  task automatic send_key(input logic [7:0] k, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_byte <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain outstanding words, then cover work that emits nothing.
  task automatic drain();
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [4:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_MAX_LEN; cfg_pwdata <= {27'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.max_len = v;
    @(posedge clk);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // A well-formed cursor sequence with random parameter text.
  task automatic send_cursor_seq();
    logic [7:0] letters [4];
    int unsigned nparm;
    letters = '{"D", "C", "H", "F"};
    send_key(tle_pkg::KeyEsc, 0);
    send_key(tle_pkg::KeyLbr, 0);
    nparm = $urandom_range(0, 3);
    if ($urandom_range(0, 4) == 0) send_key(tle_pkg::KeySpace, 0);
    if ($urandom_range(0, 4) == 0) send_key($urandom_range(0, 1) ? "-" : "+", 0);
    repeat (nparm) send_key(8'("0" + $urandom_range(0, 9)), 0);
    if ($urandom_range(0, 9) == 0) send_key(printable() | 8'h40, 0);   // any byte in 0x40..0x7f, not only letters
    else send_key(letters[$urandom_range(0, 3)], 0);
  endtask

  task automatic send_random_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) send_key(printable(), 0);
    else if (r < 62) send_key(tle_pkg::KeyBs, 0);
    else if (r < 70) send_key(tle_pkg::KeyDel, 0);
    else if (r < 82) send_cursor_seq();
    else if (r < 86) send_key(tle_pkg::KeyCr, 0);
    else if (r < 88) send_key(tle_pkg::KeyCtrlC, 0);
    else if (r < 92) send_key(tle_pkg::KeyEsc, 0);
    else if (r < 96) send_key(8'($urandom_range(8'h80, 8'hff)), 0);
    else send_key(8'($urandom_range(0, 31)), 0);
  endtask

  initial begin
    logic [4:0] settings [5];
    sb = new();
    sb.clear_all();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_on = 1;

    // Directed: fill past the limit, edit in the middle, cursor keys, controls.
    for (int i = 0; i < 17; i++) send_key(8'h20 + 8'(i * 6), 0);
    send_key(8'h7e, 0);
    send_key(tle_pkg::KeyEsc, 0); send_key(tle_pkg::KeyLbr, 0);
    send_key("3", 0); send_key("D", 0);
    send_key(tle_pkg::KeyBs, 0); send_key(tle_pkg::KeyDel, 0);
    send_key(tle_pkg::KeyEsc, 0); send_key(tle_pkg::KeyLbr, 0); send_key("H", 0);
    send_key(tle_pkg::KeyBs, 0);
    send_key(tle_pkg::KeyEsc, 0); send_key(tle_pkg::KeyLbr, 0);
    send_key("-", 0); send_key("C", 0);
    send_key(tle_pkg::KeyEsc, 0); send_key("x", 0);
    send_key(tle_pkg::KeyEsc, 0); send_key(tle_pkg::KeyLbr, 0);
    for (int i = 0; i < 9; i++) send_key("9", 0);   // collector overflows
    send_key(8'hff, 0); send_key(8'h80, 0); send_key(8'h01, 0);
    send_key(tle_pkg::KeyCr, 0);
    send_key("a", 0); send_key(tle_pkg::KeyCtrlC, 0);
    send_key(tle_pkg::KeyCr, 0);

    // Long receiver hold-off while keystrokes keep coming.
    hold_long = 1;
    for (int i = 0; i < 12; i++) send_key(printable(), 1);
    wait (!hold_long);
    drain();

    settings = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd16};
    foreach (settings[s]) begin
      write_max_len(settings[s]);
      for (int i = 0; i < 35; i++) send_random_key();
      // Lowered limit with a long line: exercise the full-line path.
      if (s == 0) send_key("z", 0);
      send_key(tle_pkg::KeyCr, 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
